// File: rtl/rtp_pkg.sv
// Shared constants and the CORDIC arctangent table for the point transform.
// Used by rtp_rot and rotate_translate_point_3d; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rtp_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;

  // inverse CORDIC gain, scaled by 2^32
  localparam logic [31:0] GAIN_INV = 32'h9B74_EDA8;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051E;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2FA;
      5'd15: a = 32'h0000_517D;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A30;
      5'd19: a = 32'h0000_0518;
      5'd20: a = 32'h0000_028C;
      5'd21: a = 32'h0000_0146;
      5'd22: a = 32'h0000_00A3;
      5'd23: a = 32'h0000_0051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rtp_rot.sv
// One pipelined plane rotation: gain scaling, quarter-turn step, CORDIC stages.
// Carries a side word along with the same latency. Uses rtp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtp_rot #(
  parameter int W  = 44,
  parameter int AW = 16,
  parameter int NS = 16,
  parameter int SW = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  wire signed [W-1:0]  in_a,
  input  wire signed [W-1:0]  in_b,
  input  wire        [AW-1:0] in_angle,
  input  wire        [SW-1:0] in_side,
  output logic                out_valid,
  output logic signed [W-1:0] out_a,
  output logic signed [W-1:0] out_b,
  output logic       [SW-1:0] out_side
);

  localparam int MW = (W > 32) ? W : 33;
  localparam int HW = MW - 32;
  localparam int ZW = 34;

  // stage A: magnitudes times gain, angle split into quarter and residual
  logic [W-1:0]     ua, ub;
  logic [MW-1:0]    ma, mb;
  logic [31:0]      full, fround;
  logic             va;
  logic             sga, sgb;
  logic [HW+31:0]   pha, phb;
  logic [63:0]      pla, plb;
  logic [1:0]       qa;
  logic signed [31:0] ra;
  logic [SW-1:0]    sidea;

  assign ua     = in_a[W-1] ? W'(-in_a) : W'(in_a);
  assign ub     = in_b[W-1] ? W'(-in_b) : W'(in_b);
  assign ma     = MW'(ua);
  assign mb     = MW'(ub);
  assign full   = {in_angle, {(32 - AW){1'b0}}};
  assign fround = full + 32'h2000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sga   <= in_a[W-1];
      sgb   <= in_b[W-1];
      pha   <= (HW+32)'(ma[MW-1:32]) * (HW+32)'(rtp_pkg::GAIN_INV);
      phb   <= (HW+32)'(mb[MW-1:32]) * (HW+32)'(rtp_pkg::GAIN_INV);
      pla   <= 64'(ma[31:0]) * 64'(rtp_pkg::GAIN_INV);
      plb   <= 64'(mb[31:0]) * 64'(rtp_pkg::GAIN_INV);
      qa    <= fround[31:30];
      ra    <= signed'(full - {fround[31:30], 30'h0});
      sidea <= in_side;
    end
  end

  // stage B: finish gain, apply sign and quarter turn
  logic [HW+32:0]     pa, pb;
  logic signed [W-1:0] ga, gb, qx, qy;

  assign pa = (HW+33)'(pha) + (HW+33)'(pla[63:32]);
  assign pb = (HW+33)'(phb) + (HW+33)'(plb[63:32]);
  assign ga = sga ? -W'(pa) : W'(pa);
  assign gb = sgb ? -W'(pb) : W'(pb);

  always_comb begin
    case (qa)
      2'd1:    begin qx = -gb; qy = ga;  end
      2'd2:    begin qx = -ga; qy = -gb; end
      2'd3:    begin qx = gb;  qy = -ga; end
      default: begin qx = ga;  qy = gb;  end
    endcase
  end

  logic signed [W-1:0]  cx [0:NS];
  logic signed [W-1:0]  cy [0:NS];
  logic signed [ZW-1:0] cz [0:NS];
  logic                 cv [0:NS];
  logic [SW-1:0]        cs [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= qx;
      cy[0] <= qy;
      cz[0] <= ZW'(ra);
      cs[0] <= sidea;
    end
  end

  // CORDIC micro-rotations, one per register stage
  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(rtp_pkg::atan_turn(5'(k)));

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (en) begin
        cv[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[k+1] <= cs[k];
        if (!cz[k][ZW-1]) begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          cy[k+1] <= cy[k] + (cx[k] >>> k);
          cz[k+1] <= cz[k] - AT;
        end else begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          cy[k+1] <= cy[k] - (cx[k] >>> k);
          cz[k+1] <= cz[k] + AT;
        end
      end
    end
  end

  assign out_valid = cv[NS];
  assign out_a     = cx[NS];
  assign out_b     = cy[NS];
  assign out_side  = cs[NS];

`ifndef SYNTHESIS
  // stalled pipeline keeps its occupancy
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cv[0]) && $stable(cv[NS]) && $stable(va))
    else $error("rtp_rot: valid moved during stall");

  // residual after the quarter step lies within one eighth turn
  a_resid: assert property (@(posedge clk) disable iff (rst)
    cv[0] |-> (cz[0] >= -(ZW'(34'sh2000_0000))) && (cz[0] < ZW'(34'sh2000_0000)))
    else $error("rtp_rot: quarter residual out of range");

  // CORDIC converges: residual angle ends small
  a_conv: assert property (@(posedge clk) disable iff (rst)
    cv[NS] |-> (cz[NS] < (ZW'(1) <<< (31 - NS))) && (cz[NS] > -(ZW'(1) <<< (31 - NS))))
    else $error("rtp_rot: CORDIC residual did not converge");
`endif

endmodule
`default_nettype wire

// File: rtl/rotate_translate_point_3d.sv
// Top level of the 3D point transform: three chained plane rotations and the
// output stage. Uses rtp_pkg and rtp_rot.
`timescale 1ns / 1ps
`default_nettype none
// Rotates a signed Q16.16 point about x, then y, then z by binary angles
// (2^ANGLE_WIDTH is one turn), adds shift_distance to x, rounds and saturates.
// One transfer is accepted every cycle while the output is not stalled; the
// path runs through the three CORDIC pipelines (each a gain multiply stage, a
// quarter-turn stage and one stage per micro-rotation) and then the output
// register. A stall on the output side freezes the whole pipeline.
module rotate_translate_point_3d #(
  parameter int COORD_WIDTH   = rtp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = rtp_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = rtp_pkg::CORDIC_STAGES_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x, point_y, point_z, angle_about_x, angle_about_y, angle_about_z,
  // shift_distance
  input  wire  [((4*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // result_x, result_y, result_z
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int C  = COORD_WIDTH;
  localparam int A  = ANGLE_WIDTH;
  localparam int NS = (CORDIC_STAGES > rtp_pkg::TABLE_LEN) ? rtp_pkg::TABLE_LEN
                                                           : CORDIC_STAGES;
  localparam int W  = C + 12;
  localparam int OBW = ((3*C+7)/8)*8;

  localparam logic signed [W+1:0] MAXV = {{(W+3-C){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [W+1:0] MINV = ~MAXV;

  // round off the 8 guard bits and clamp to the coordinate range
  function automatic logic [C-1:0] finish(input logic signed [W:0] v);
    logic signed [W+1:0] r;
    r = ((W+2)'(v) + (W+2)'(128)) >>> 8;
    if (r > MAXV) begin
      r = MAXV;
    end else if (r < MINV) begin
      r = MINV;
    end
    return r[C-1:0];
  endfunction

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack and widen to the internal format
  logic signed [C-1:0] px, py, pz, pd;
  logic [A-1:0]        ax, ay, az;
  logic signed [W-1:0] wx, wy, wz, wd;

  assign px = s_axis_tdata[C-1:0];
  assign py = s_axis_tdata[2*C-1:C];
  assign pz = s_axis_tdata[3*C-1:2*C];
  assign ax = s_axis_tdata[3*C+A-1:3*C];
  assign ay = s_axis_tdata[3*C+2*A-1:3*C+A];
  assign az = s_axis_tdata[3*C+3*A-1:3*C+2*A];
  assign pd = s_axis_tdata[4*C+3*A-1:3*C+3*A];
  assign wx = W'(px) <<< 8;
  assign wy = W'(py) <<< 8;
  assign wz = W'(pz) <<< 8;
  assign wd = W'(pd) <<< 8;

  // rotation about x: (y, z)
  logic                r1v;
  logic signed [W-1:0] r1y, r1z;
  logic [2*W+2*A-1:0]  r1s;

  rtp_rot #(.W(W), .AW(A), .NS(NS), .SW(2*W+2*A)) u_rot_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid), .in_a(wy), .in_b(wz), .in_angle(ax),
    .in_side({wd, az, ay, wx}),
    .out_valid(r1v), .out_a(r1y), .out_b(r1z), .out_side(r1s)
  );

  // rotation about y: (z, x)
  logic                r2v;
  logic signed [W-1:0] r2z, r2x;
  logic [2*W+A-1:0]    r2s;

  rtp_rot #(.W(W), .AW(A), .NS(NS), .SW(2*W+A)) u_rot_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(r1v), .in_a(r1z), .in_b(signed'(r1s[W-1:0])), .in_angle(r1s[W+A-1:W]),
    .in_side({r1s[2*W+2*A-1:W+2*A], r1s[W+2*A-1:W+A], r1y}),
    .out_valid(r2v), .out_a(r2z), .out_b(r2x), .out_side(r2s)
  );

  // rotation about z: (x, y)
  logic                r3v;
  logic signed [W-1:0] r3x, r3y;
  logic [2*W-1:0]      r3s;

  rtp_rot #(.W(W), .AW(A), .NS(NS), .SW(2*W)) u_rot_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(r2v), .in_a(r2x), .in_b(signed'(r2s[W-1:0])), .in_angle(r2s[W+A-1:W]),
    .in_side({r2s[2*W+A-1:W+A], r2z}),
    .out_valid(r3v), .out_a(r3x), .out_b(r3y), .out_side(r3s)
  );

  // translate, round, saturate into the output register
  logic signed [W-1:0] fz, fd;
  logic [C-1:0]        rx, ry, rz;

  assign fz = r3s[W-1:0];
  assign fd = r3s[2*W-1:W];
  assign rx = finish((W+1)'(r3x) + (W+1)'(fd));
  assign ry = finish((W+1)'(r3y));
  assign rz = finish((W+1)'(fz));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= r3v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OBW'({rz, ry, rx});
    end
  end

`ifndef SYNTHESIS
  // a result leaves only after something reached the last rotation
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(r3v))
    else $error("rotate_translate_point_3d: output without source");

  // a stalled result keeps the pipeline frozen
  a_frz: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(r3v) && $stable(r3x))
    else $error("rotate_translate_point_3d: pipeline moved under stall");

  // input is refused exactly while a result is stalled
  a_bp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("rotate_translate_point_3d: input taken during stall");
`endif

endmodule
`default_nettype wire
